/* hw/rtl/ie_pkg.sv */
// Shared types and constants for the instruction execute block.
// Used by the memory, register file, sequencer and top level.
package ie_pkg;

    localparam int ADDR_BITS  = 16;
    localparam int MAX_STRING = 63;
    localparam int CNT_BITS   = 6;

    localparam logic [2:0] OP_WRITE   = 3'd0;
    localparam logic [2:0] OP_STEP    = 3'd1;
    localparam logic [2:0] OP_SET_PC  = 3'd2;
    localparam logic [2:0] OP_READ    = 3'd3;
    localparam logic [2:0] OP_READ_RG = 3'd4;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_CHAR   = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam logic [1:0] FLT_NONE  = 2'd0;
    localparam logic [1:0] FLT_RSVD  = 2'd1;
    localparam logic [1:0] FLT_RTI   = 2'd2;
    localparam logic [1:0] FLT_PUTSP = 2'd3;

    localparam logic [3:0] OPC_BR   = 4'd0;
    localparam logic [3:0] OPC_ADD  = 4'd1;
    localparam logic [3:0] OPC_LD   = 4'd2;
    localparam logic [3:0] OPC_ST   = 4'd3;
    localparam logic [3:0] OPC_JSR  = 4'd4;
    localparam logic [3:0] OPC_AND  = 4'd5;
    localparam logic [3:0] OPC_LDR  = 4'd6;
    localparam logic [3:0] OPC_STR  = 4'd7;
    localparam logic [3:0] OPC_RTI  = 4'd8;
    localparam logic [3:0] OPC_NOT  = 4'd9;
    localparam logic [3:0] OPC_LDI  = 4'd10;
    localparam logic [3:0] OPC_STI  = 4'd11;
    localparam logic [3:0] OPC_JMP  = 4'd12;
    localparam logic [3:0] OPC_RSVD = 4'd13;
    localparam logic [3:0] OPC_LEA  = 4'd14;
    localparam logic [3:0] OPC_TRAP = 4'd15;

    localparam logic [7:0] TV_GETC  = 8'h20;
    localparam logic [7:0] TV_OUT   = 8'h21;
    localparam logic [7:0] TV_PUTS  = 8'h22;
    localparam logic [7:0] TV_IN    = 8'h23;
    localparam logic [7:0] TV_PUTSP = 8'h24;
    localparam logic [7:0] TV_HALT  = 8'h25;

    // one memory access request from the sequencer
    typedef struct packed {
        logic                 we;
        logic [ADDR_BITS-1:0] addr;
        logic [15:0]          wdata;
    } mem_req_t;

    // one register file access: two read port addresses and an optional write
    typedef struct packed {
        logic [2:0]  raddr_a;
        logic [2:0]  raddr_b;
        logic        we;
        logic [2:0]  waddr;
        logic [15:0] wdata;
    } rf_req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  char_out;
        logic [15:0] read_data;
        logic [15:0] pc_now;
        logic [2:0]  cond_flags;
        logic        halted;
        logic [1:0]  fault;
        logic        truncated;
        logic        last;
    } result_t;

    function automatic logic [15:0] sext(input logic [15:0] v, input int bits);
        logic [15:0] r;
        r = v;
        for (int i = 0; i < 16; i++)
            if (i >= bits) r[i] = v[bits-1];
        return r;
    endfunction

    function automatic logic [2:0] nzp(input logic [15:0] v);
        logic [2:0] r;
        if (v == 16'd0)  r = 3'b010;
        else if (v[15])  r = 3'b100;
        else             r = 3'b001;
        return r;
    endfunction

endpackage

/* hw/rtl/ie_main_mem.sv */
// Main memory: single-port synchronous RAM with a registered read.
// Depends on ie_pkg.
module ie_main_mem
    import ie_pkg::*;
(
    input  logic        clk,
    input  mem_req_t    req,
    input  logic        en,
    output logic [15:0] rdata
);

    logic [15:0] mem [2**ADDR_BITS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (req.we)
                mem[req.addr] <= req.wdata;
            rdata <= mem[req.addr];
        end
    end

endmodule

/* hw/rtl/ie_regfile.sv */
// Eight general registers, reset to zero, two combinational read ports.
// Depends on ie_pkg.
module ie_regfile
    import ie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rf_req_t     req,
    output logic [15:0] rdata_a,
    output logic [15:0] rdata_b
);

    logic [15:0] regs_reg [8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                regs_reg[i] <= 16'd0;
        end
        else if (req.we)
        begin
            regs_reg[req.waddr] <= req.wdata;
        end
    end

    assign rdata_a = regs_reg[req.raddr_a];
    assign rdata_b = regs_reg[req.raddr_b];

endmodule

/* hw/rtl/ie_seq.sv */
// Operation sequencer: fetch, decode, memory access and result output.
// Depends on ie_pkg; drives ie_main_mem and ie_regfile.
module ie_seq
    import ie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [15:0] address,
    input  logic [15:0] write_data,
    input  logic [2:0]  reg_index,
    input  logic [7:0]  in_char,
    output mem_req_t    mreq,
    output logic        men,
    input  logic [15:0] mrdata,
    output rf_req_t     rreq,
    input  logic [15:0] rf_a,
    input  logic [15:0] rf_b,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_res
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_IND   = 3'd3;
    localparam logic [2:0] S_DATA  = 3'd4;
    localparam logic [2:0] S_PUTS  = 3'd5;
    localparam logic [2:0] S_RDOUT = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [15:0] pc_reg, pc_next;
    logic [2:0]  cc_reg, cc_next;
    logic [15:0] ir_reg, ir_next;
    logic [15:0] ptr_reg, ptr_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [7:0]  ich_reg, ich_next;
    logic        ov_reg, ov_next;
    result_t     res_reg, res_next;

    logic [15:0] pc9, off6, addr_r, alu_b, alu_v, jsr_t;
    logic [3:0]  opc;
    logic        take;
    logic        out_free;
    result_t     fin;

    assign opc    = ir_reg[15:12];
    assign pc9    = pc_reg + sext(ir_reg, 9);
    assign off6   = sext(ir_reg, 6);
    assign addr_r = rf_a + off6;
    assign alu_b  = ir_reg[5] ? sext(ir_reg, 5) : rf_b;
    assign alu_v  = (opc == OPC_ADD) ? rf_a + alu_b : rf_a & alu_b;
    assign jsr_t  = ir_reg[11] ? pc_reg + sext(ir_reg, 11) : rf_a;

    assign out_free  = !ov_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign take      = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        cc_next    = cc_reg;
        ir_next    = ir_reg;
        ptr_next   = ptr_reg;
        cnt_next   = cnt_reg;
        ich_next   = ich_reg;
        ov_next    = ov_reg && !out_ready;
        res_next   = res_reg;
        mreq       = '0;
        men        = 1'b0;
        rreq       = '0;
        rreq.raddr_a = ir_reg[8:6];
        rreq.raddr_b = ir_reg[2:0];
        fin        = '0;
        fin.kind   = KIND_STATUS;
        fin.last   = 1'b1;
        fin.pc_now = pc_reg;
        fin.cond_flags = cc_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    mreq.addr  = address[ADDR_BITS-1:0];
                    mreq.wdata = write_data;
                    ich_next   = in_char;
                    case (operation)
                        OP_WRITE:
                        begin
                            mreq.we = 1'b1;
                            men     = 1'b1;
                            ov_next = 1'b1;
                            res_next = fin;
                        end
                        OP_SET_PC:
                        begin
                            pc_next  = address;
                            ov_next  = 1'b1;
                            res_next = fin;
                            res_next.pc_now = address;
                        end
                        OP_READ:
                        begin
                            men        = 1'b1;
                            state_next = S_RDOUT;
                        end
                        OP_READ_RG:
                        begin
                            rreq.raddr_a = reg_index;
                            ov_next  = 1'b1;
                            res_next = fin;
                            res_next.kind = KIND_READ;
                            res_next.read_data = rf_a;
                        end
                        OP_STEP:
                        begin
                            mreq.addr  = pc_reg[ADDR_BITS-1:0];
                            men        = 1'b1;
                            state_next = S_FETCH;
                        end
                        default:
                        begin
                            ov_next  = 1'b1;
                            res_next = fin;
                        end
                    endcase
                end
            end
            S_RDOUT:
            begin
                if (out_free)
                begin
                    ov_next  = 1'b1;
                    res_next = fin;
                    res_next.kind = KIND_READ;
                    res_next.read_data = mrdata;
                    state_next = S_IDLE;
                end
            end
            S_FETCH:
            begin
                ir_next    = mrdata;
                pc_next    = pc_reg + 16'd1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                // hold while the OUT character still waits in the output register
                if (out_free)
                begin
                    // every path ends on a status result except LD, LDR, LDI, STI, OUT and PUTS
                    state_next = S_IDLE;
                    case (opc)
                        OPC_ADD, OPC_AND:
                        begin
                            rreq.we = 1'b1; rreq.waddr = ir_reg[11:9];
                            rreq.wdata = alu_v; cc_next = nzp(alu_v);
                        end
                        OPC_NOT:
                        begin
                            rreq.we = 1'b1; rreq.waddr = ir_reg[11:9];
                            rreq.wdata = ~rf_a; cc_next = nzp(~rf_a);
                        end
                        OPC_BR:
                            if ((ir_reg[11:9] & cc_reg) != 3'd0) pc_next = pc9;
                        OPC_JMP:
                            pc_next = rf_a;
                        OPC_JSR:
                        begin
                            rreq.we = 1'b1; rreq.waddr = 3'd7;
                            rreq.wdata = pc_reg; pc_next = jsr_t;
                        end
                        OPC_LEA:
                        begin
                            rreq.we = 1'b1; rreq.waddr = ir_reg[11:9];
                            rreq.wdata = pc9; cc_next = nzp(pc9);
                        end
                        OPC_LD:
                        begin
                            men = 1'b1; mreq.addr = pc9[ADDR_BITS-1:0];
                            state_next = S_DATA;
                        end
                        OPC_LDR:
                        begin
                            men = 1'b1; mreq.addr = addr_r[ADDR_BITS-1:0];
                            state_next = S_DATA;
                        end
                        OPC_LDI, OPC_STI:
                        begin
                            men = 1'b1; mreq.addr = pc9[ADDR_BITS-1:0];
                            state_next = S_IND;
                        end
                        OPC_ST:
                        begin
                            rreq.raddr_a = ir_reg[11:9];
                            men = 1'b1; mreq.we = 1'b1;
                            mreq.addr = pc9[ADDR_BITS-1:0]; mreq.wdata = rf_a;
                        end
                        OPC_STR:
                        begin
                            rreq.raddr_b = ir_reg[11:9];
                            men = 1'b1; mreq.we = 1'b1;
                            mreq.addr = addr_r[ADDR_BITS-1:0]; mreq.wdata = rf_b;
                        end
                        OPC_TRAP:
                        begin
                            rreq.raddr_a = 3'd0;
                            case (ir_reg[7:0])
                                TV_GETC, TV_IN:
                                begin
                                    rreq.we = 1'b1; rreq.waddr = 3'd0;
                                    rreq.wdata = {8'd0, ich_reg};
                                end
                                TV_OUT:
                                begin
                                    // character first from S_DATA, then status from S_EXEC
                                    state_next = S_DATA;
                                    ptr_next   = rf_a;
                                end
                                TV_PUTS:
                                begin
                                    ptr_next = rf_a; cnt_next = '0;
                                    men = 1'b1; mreq.addr = rf_a[ADDR_BITS-1:0];
                                    state_next = S_PUTS;
                                end
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                    if (state_next == S_IDLE)
                    begin
                        ov_next  = 1'b1;
                        res_next = fin;
                        res_next.pc_now = pc_next;
                        res_next.cond_flags = cc_next;
                        if (opc == OPC_RTI) res_next.fault = FLT_RTI;
                        else if (opc == OPC_RSVD) res_next.fault = FLT_RSVD;
                        else if (opc == OPC_TRAP && ir_reg[7:0] == TV_PUTSP)
                            res_next.fault = FLT_PUTSP;
                        res_next.halted = (opc == OPC_TRAP) && (ir_reg[7:0] == TV_HALT);
                    end
                end
            end
            S_IND:
            begin
                rreq.raddr_a = ir_reg[11:9];
                men = 1'b1;
                mreq.addr = mrdata[ADDR_BITS-1:0];
                if (opc == OPC_STI)
                begin
                    if (out_free)
                    begin
                        mreq.we = 1'b1; mreq.wdata = rf_a;
                        ov_next = 1'b1; res_next = fin;
                        state_next = S_IDLE;
                    end
                    else
                        men = 1'b0;
                end
                else
                    state_next = S_DATA;
            end
            S_DATA:
            begin
                if (out_free)
                begin
                    if (opc == OPC_TRAP)
                    begin
                        // OUT: emit the character, then go back for status
                        ov_next = 1'b1; res_next = fin;
                        res_next.kind = KIND_CHAR; res_next.last = 1'b0;
                        res_next.char_out = ptr_reg[7:0];
                        ir_next = {OPC_TRAP, 12'h000};
                        state_next = S_EXEC;
                    end
                    else
                    begin
                        rreq.we = 1'b1; rreq.waddr = ir_reg[11:9];
                        rreq.wdata = mrdata; cc_next = nzp(mrdata);
                        ov_next = 1'b1; res_next = fin;
                        res_next.cond_flags = nzp(mrdata);
                        state_next = S_IDLE;
                    end
                end
            end
            S_PUTS:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1; res_next = fin;
                    if (mrdata == 16'd0 || cnt_reg == CNT_BITS'(MAX_STRING))
                    begin
                        res_next.truncated = (mrdata != 16'd0);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        res_next.kind = KIND_CHAR; res_next.last = 1'b0;
                        res_next.char_out = mrdata[7:0];
                        cnt_next = cnt_reg + 1'b1;
                        ptr_next = ptr_reg + 16'd1;
                        men = 1'b1;
                        mreq.addr = ptr_next[ADDR_BITS-1:0];
                        // stay: wait for the next word
                        state_next = S_PUTS;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= 16'h3000;
            cc_reg    <= 3'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            cc_reg    <= cc_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ir_reg  <= ir_next;
        ptr_reg <= ptr_next;
        cnt_reg <= cnt_next;
        ich_reg <= ich_next;
        res_reg <= res_next;
    end

endmodule

/* hw/rtl/lc3_instruction_execute.sv */
// Top level of the instruction execute block.
// Depends on ie_pkg, ie_main_mem, ie_regfile and ie_seq.
//
// One request is taken at a time. Write, set pc and register read answer
// from idle; a memory read waits in S_RDOUT. A step fetches, executes, then
// uses the single memory port once more for LD/LDR and twice for LDI/STI;
// PUTS reads one word per character. Results stall the sequencer through
// the one-entry output register. Memory contents are undefined at reset.
module lc3_instruction_execute
    import ie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: operation[2:0], address[18:3], write_data[34:19],
    //        reg_index[37:35], in_char[45:38], zero[47:46]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: char_out[7:0], read_data[23:8], pc_now[39:24],
    //        cond_flags[42:40], halted[43], fault[45:44], truncated[46], zero[47]
    output logic [47:0] m_tdata,
    // tuser: kind[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    mem_req_t    mreq;
    logic        men;
    logic [15:0] mrdata;
    rf_req_t     rreq;
    logic [15:0] rf_a, rf_b;
    result_t     res;

    ie_main_mem u_mem (.clk(clk), .req(mreq), .en(men), .rdata(mrdata));

    ie_regfile u_rf (.clk(clk), .rst_n(rst_n), .req(rreq),
                     .rdata_a(rf_a), .rdata_b(rf_b));

    ie_seq u_seq (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .operation(s_tdata[2:0]), .address(s_tdata[18:3]),
        .write_data(s_tdata[34:19]), .reg_index(s_tdata[37:35]),
        .in_char(s_tdata[45:38]),
        .mreq(mreq), .men(men), .mrdata(mrdata),
        .rreq(rreq), .rf_a(rf_a), .rf_b(rf_b),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tdata = {1'b0, res.truncated, res.fault, res.halted, res.cond_flags,
                      res.pc_now, res.read_data, res.char_out};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

/* hw/rtl/ie_checker.sv */
// Port-level checks for the instruction execute block, bound to the top.
// Depends on ie_pkg.
module ie_port_checks
    import ie_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");

    a_char_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_CHAR |-> !m_tlast)
        else $error("character result marked last");

    a_read_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_READ |-> m_tlast && m_tdata[47:43] == 5'd0)
        else $error("read result carries status");

    a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while result stalled");

endmodule

bind lc3_instruction_execute ie_port_checks u_ie_port_checks (.*);
